// ----- hw/rtl/sat_pkg.sv -----
// shared types and constants for the shifting array table
package sat_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned POS_W           = 13;
  localparam int unsigned DEPTH_DEFAULT   = 64;
  localparam int unsigned INIT_SIZE_RESET = 8;

  typedef enum logic [2:0] {
    FN_GET    = 3'd0,
    FN_SET    = 3'd1,
    FN_APPEND = 3'd2,
    FN_INSERT = 3'd3,
    FN_REMOVE = 3'd4,
    FN_GROW   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_RANGE    = 2'd1,
    ERR_CAPACITY = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [POS_W-1:0]    pos;
    logic [POS_W-1:0]    size;
    logic [DATA_W-1:0]   value;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/shifting_array_table.sv -----
// shifting array table: done follows start in the next cycle, one word per cycle while cfg_we is low
// every operation, including insert and remove, completes without a busy state
// because all cells shift to their neighbours in parallel; busy stays low
// the receiver cannot stall: done and the result ports are valid for one cycle
// synchronous reset clears all entries and the fill count, size becomes 8
// clamped to DEPTH; a cfg write reloads the size and clears entries beyond it
module shifting_array_table #(
  parameter int unsigned DEPTH = sat_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 func,
  input  logic [7:0]                 index,
  input  logic signed [31:0]         value,
  input  logic [7:0]                 new_size,
  input  logic                       cfg_we,
  input  logic [6:0]                 cfg_data,
  output logic                       done,
  output logic signed [31:0]         read_value,
  output logic [1:0]                 error,
  output logic [6:0]                 size_now,
  output logic [6:0]                 count_now
);
  import sat_pkg::*;

  localparam int unsigned SW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (SW > 8) ? SW + 1 : 9;
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned RESET_SIZE = (INIT_SIZE_RESET > DEPTH) ? DEPTH : INIT_SIZE_RESET;

  logic [SW-1:0]      size_q;
  logic [SW-1:0]      count_q;
  logic [DATA_W-1:0]  cell_q [DEPTH];
  cell_ctrl_t         ctrl;

  logic [CW-1:0]      size_c, count_c, idx_c, req_c, depth_c, dbl_c, grown_c, cfg_c;
  logic [CW-1:0]      size_next, count_next, cfg_size;
  logic [IW+7:0]      idx_ext;
  logic [IW-1:0]      rd_addr;
  logic               idx_oob, full, at_max, accept;
  logic [DATA_W-1:0]  rd_next;
  err_t               err_next;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign size_c  = CW'(size_q);
  assign count_c = CW'(count_q);
  assign idx_c   = CW'(index);
  assign req_c   = CW'(new_size);
  assign depth_c = CW'(DEPTH);
  assign dbl_c   = size_c << 1;
  assign grown_c = (dbl_c > depth_c) ? depth_c : dbl_c;
  assign cfg_c   = CW'(cfg_data);
  assign idx_ext = (IW + 8)'(index);
  assign rd_addr = idx_ext[IW-1:0];
  assign idx_oob = idx_c >= size_c;
  assign full    = count_c >= size_c;
  assign at_max  = size_c >= depth_c;

  always_comb begin
    size_next   = size_c;
    count_next  = count_c;
    rd_next     = '0;
    err_next    = ERR_OK;
    cfg_size    = (cfg_c == '0) ? CW'(1) : ((cfg_c > depth_c) ? depth_c : cfg_c);
    ctrl.op     = CELL_HOLD;
    ctrl.pos    = POS_W'(idx_c);
    ctrl.size   = POS_W'(size_c);
    ctrl.value  = value;
    if (cfg_we) begin
      size_next  = cfg_size;
      count_next = (count_c > cfg_size) ? cfg_size : count_c;
      ctrl.op    = CELL_CLEAR;
      ctrl.size  = POS_W'(cfg_size);
    end else if (accept) begin
      case (func_t'(func))
        FN_GET: begin
          if (idx_oob) err_next = ERR_RANGE;
          else         rd_next  = cell_q[rd_addr];
        end
        FN_SET: begin
          if (idx_oob) begin
            err_next = ERR_RANGE;
          end else begin
            ctrl.op = CELL_WRITE;
            if (idx_c >= count_c) count_next = idx_c + CW'(1);
          end
        end
        FN_APPEND: begin
          if (full && at_max) begin
            err_next = ERR_CAPACITY;
          end else begin
            if (full) size_next = grown_c;
            ctrl.op    = CELL_WRITE;
            ctrl.pos   = POS_W'(count_c);
            count_next = count_c + CW'(1);
          end
        end
        FN_INSERT: begin
          if (idx_oob) begin
            err_next = ERR_RANGE;
          end else if (full && at_max) begin
            err_next = ERR_CAPACITY;
          end else begin
            if (full) size_next = grown_c;
            ctrl.op    = CELL_INSERT;
            ctrl.size  = POS_W'(full ? grown_c : size_c);
            count_next = count_c + CW'(1);
          end
        end
        FN_REMOVE: begin
          if (idx_oob || count_c == '0) begin
            err_next = ERR_RANGE;
          end else begin
            rd_next    = cell_q[rd_addr];
            ctrl.op    = CELL_REMOVE;
            count_next = count_c - CW'(1);
          end
        end
        FN_GROW: begin
          if (req_c > size_c) begin
            if (req_c > depth_c) err_next  = ERR_CAPACITY;
            else                 size_next = req_c;
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar p = 0; p < DEPTH; p++) begin : g_cell
    logic [DATA_W-1:0] left_d, right_d;
    if (p == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[p-1];
    end
    if (p == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[p+1];
    end
    sat_cell #(.POS(p)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  (left_d),
      .right (right_d),
      .q     (cell_q[p])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_q  <= SW'(RESET_SIZE);
      count_q <= '0;
      done    <= 1'b0;
    end else begin
      size_q  <= SW'(size_next);
      count_q <= SW'(count_next);
      done    <= accept && !cfg_we;
    end
    read_value <= rd_next;
    error      <= err_next;
    size_now   <= size_next[6:0];
    count_now  <= count_next[6:0];
  end

  a_count_le_size: assert property (@(posedge clk) disable iff (rst)
    count_q <= size_q) else $error("fill count above size");

  a_size_range: assert property (@(posedge clk) disable iff (rst)
    size_q != '0 && CW'(size_q) <= depth_c) else $error("size out of range");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_we |=> done) else $error("word accepted without result");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    done && error != ERR_OK |-> read_value == '0) else $error("data on error");

endmodule

// ----- hw/rtl/sat_cell.sv -----
// one storage cell of the table, shifting with its neighbours
module sat_cell #(
  parameter int unsigned POS = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sat_pkg::cell_ctrl_t        ctrl,
  input  logic [sat_pkg::DATA_W-1:0] left,
  input  logic [sat_pkg::DATA_W-1:0] right,
  output logic [sat_pkg::DATA_W-1:0] q
);
  import sat_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

  logic [DATA_W-1:0] q_next;
  logic [POS_W-1:0]  last_pos;

  assign last_pos = ctrl.size - POS_W'(1);

  always_comb begin
    q_next = q;
    unique case (ctrl.op)
      CELL_WRITE: begin
        if (MY_POS == ctrl.pos) q_next = ctrl.value;
      end
      CELL_INSERT: begin
        if (MY_POS == ctrl.pos) begin
          q_next = ctrl.value;
        end else if (MY_POS > ctrl.pos && MY_POS < ctrl.size) begin
          q_next = left;
        end
      end
      CELL_REMOVE: begin
        if (MY_POS == last_pos) begin
          q_next = '0;
        end else if (MY_POS >= ctrl.pos && MY_POS < ctrl.size) begin
          q_next = right;
        end
      end
      CELL_CLEAR: begin
        if (MY_POS >= ctrl.size) q_next = '0;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

// ----- verif/shifting_array_table_test.sv -----
// self-checking testbench for the shifting array table: directed, capacity and random traffic
`timescale 1ns / 100ps
module shifting_array_table_test;
  import sat_pkg::*;

  localparam int unsigned SLOTS = DEPTH_DEFAULT;
  localparam logic [2:0] FN_SPARE_LO = 3'd6;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [31:0] read_value;
    err_t               error;
    logic [6:0]         size_now;
    logic [6:0]         count_now;
  } table_word_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         func;
  logic [7:0]         index;
  logic signed [31:0] value;
  logic [7:0]         new_size;
  logic               cfg_we;
  logic [6:0]         cfg_data;
  logic               done;
  logic signed [31:0] read_value;
  logic [1:0]         error;
  logic [6:0]         size_now;
  logic [6:0]         count_now;

  logic signed [31:0] slot_mem [SLOTS];
  int unsigned        cur_size;
  int unsigned        cur_count;
  table_word_t        pending_words [$];
  int unsigned        mismatches;
  bit                 gaps_on;

  shifting_array_table uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .index      (index),
    .value      (value),
    .new_size   (new_size),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .done       (done),
    .read_value (read_value),
    .error      (error),
    .size_now   (size_now),
    .count_now  (count_now)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned clamp_size(int unsigned v);
    if (v < 1) return 1;
    if (v > SLOTS) return SLOTS;
    return v;
  endfunction

  function automatic bit make_room();
    if (cur_count < cur_size) return 1'b1;
    if (cur_size >= SLOTS) return 1'b0;
    cur_size = clamp_size(cur_size * 2);
    return 1'b1;
  endfunction

  function automatic table_word_t predict_word(logic [2:0] f, logic [7:0] idx,
                                               logic signed [31:0] val, logic [7:0] req);
    table_word_t w;
    int unsigned i;
    w.read_value = '0;
    w.error      = ERR_OK;
    case (f)
      FN_GET: begin
        if (idx >= cur_size) w.error = ERR_RANGE;
        else w.read_value = slot_mem[idx];
      end
      FN_SET: begin
        if (idx >= cur_size) begin
          w.error = ERR_RANGE;
        end else begin
          slot_mem[idx] = val;
          if (idx >= cur_count) cur_count = idx + 1;
        end
      end
      FN_APPEND: begin
        if (!make_room()) begin
          w.error = ERR_CAPACITY;
        end else begin
          slot_mem[cur_count] = val;
          cur_count++;
        end
      end
      FN_INSERT: begin
        if (idx >= cur_size) begin
          w.error = ERR_RANGE;
        end else if (!make_room()) begin
          w.error = ERR_CAPACITY;
        end else begin
          for (i = cur_size - 1; i > idx; i--) slot_mem[i] = slot_mem[i - 1];
          slot_mem[idx] = val;
          cur_count++;
        end
      end
      FN_REMOVE: begin
        if (idx >= cur_size || cur_count == 0) begin
          w.error = ERR_RANGE;
        end else begin
          w.read_value = slot_mem[idx];
          for (i = idx; i + 1 < cur_size; i++) slot_mem[i] = slot_mem[i + 1];
          slot_mem[cur_size - 1] = '0;
          cur_count--;
        end
      end
      FN_GROW: begin
        if (req > cur_size) begin
          if (req > SLOTS) w.error = ERR_CAPACITY;
          else cur_size = 32'(req);
        end
      end
      default: ;
    endcase
    w.size_now  = cur_size[6:0];
    w.count_now = cur_count[6:0];
    return w;
  endfunction

  task automatic send_word(input logic [2:0] f, input logic [7:0] idx,
                           input logic signed [31:0] val, input logic [7:0] req);
    @(negedge clk);
    start    <= 1'b1;
    func     <= f;
    index    <= idx;
    value    <= val;
    new_size <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_words.push_back(predict_word(f, idx, val, req));
  endtask

  task automatic pause_random();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain_and_settle();
    @(negedge clk) start <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_size(input logic [6:0] sz);
    int unsigned i;
    drain_and_settle();
    cfg_we   <= 1'b1;
    cfg_data <= sz;
    @(posedge clk);
    cur_size = clamp_size(32'(sz));
    if (cur_count > cur_size) cur_count = cur_size;
    for (i = cur_size; i < SLOTS; i++) slot_mem[i] = '0;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    // remove while empty, then range edges, doubling, shifts and grow cases
    send_word(FN_REMOVE, 8'd0, 32'sd0, 8'd0);
    send_word(FN_GET, 8'd0, 32'sd0, 8'd0);
    send_word(FN_GET, 8'd255, 32'sd0, 8'd0);
    send_word(FN_SET, 8'd7, 32'sh7fffffff, 8'd0);
    send_word(FN_SET, 8'd8, 32'sh1234_5678, 8'd0);
    send_word(FN_GET, 8'd7, 32'sd0, 8'd0);
    send_word(FN_APPEND, 8'd0, 32'sh8000_0000, 8'd0);
    send_word(FN_INSERT, 8'd0, -32'sd1, 8'd0);
    send_word(FN_INSERT, 8'd15, 32'sh5555_5555, 8'd0);
    send_word(FN_INSERT, 8'd16, 32'sh0f0f_0f0f, 8'd0);
    send_word(FN_REMOVE, 8'd0, 32'sd0, 8'd0);
    send_word(FN_REMOVE, 8'd15, 32'sd0, 8'd0);
    send_word(FN_REMOVE, 8'd200, 32'sd0, 8'd0);
    send_word(FN_GROW, 8'd0, 32'sd0, 8'd4);
    send_word(FN_GROW, 8'd0, 32'sd0, 8'd16);
    send_word(FN_GROW, 8'd0, 32'sd0, 8'd64);
    send_word(FN_GROW, 8'd0, 32'sd0, 8'd65);
    send_word(FN_GROW, 8'd0, 32'sd0, 8'd255);
    send_word(FN_SPARE_LO, 8'd3, 32'sh7fff_ffff, 8'd100);
    send_word(FN_SPARE_HI, 8'd255, -32'sd1, 8'd255);
    send_word(FN_SET, 8'd63, 32'shaaaa_aaaa, 8'd0);
    send_word(FN_GET, 8'd63, 32'sd0, 8'd0);
    send_word(FN_GET, 8'd64, 32'sd0, 8'd0);
  endtask

  task automatic test_capacity_limit();
    write_size(7'd40);
    while (cur_count < cur_size) send_word(FN_APPEND, 8'd0, $urandom, 8'd0);
    // doubling past the depth clamps to it
    send_word(FN_APPEND, 8'd0, $urandom, 8'd0);
    while (cur_count < SLOTS) send_word(FN_APPEND, 8'd0, $urandom, 8'd0);
    send_word(FN_APPEND, 8'd0, $urandom, 8'd0);
    send_word(FN_INSERT, 8'd5, $urandom, 8'd0);
    send_word(FN_INSERT, 8'd200, $urandom, 8'd0);
    send_word(FN_GET, 8'd63, 32'sd0, 8'd0);
  endtask

  task automatic random_word(input bit filling);
    int unsigned        r;
    int unsigned        pick;
    logic [2:0]         f;
    logic [7:0]         idx;
    logic [7:0]         req;
    logic signed [31:0] val;
    pick = $urandom_range(0, 15);
    case (pick)
      0: val = 32'sh7fff_ffff;
      1: val = 32'sh8000_0000;
      2: val = 32'sd0;
      3: val = -32'sd1;
      default: val = $urandom;
    endcase
    idx = 8'($urandom_range(0, cur_size - 1));
    req = 8'($urandom_range(cur_size, SLOTS));
    if ($urandom_range(0, 9) == 0) idx = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) req = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 35) f = FN_APPEND;
      else if (r < 55) f = FN_INSERT;
      else if (r < 65) f = FN_SET;
      else if (r < 80) f = FN_GET;
      else if (r < 93) f = FN_REMOVE;
      else f = FN_GROW;
    end else begin
      if (r < 45) f = FN_REMOVE;
      else if (r < 65) f = FN_GET;
      else if (r < 75) f = FN_SET;
      else if (r < 85) f = FN_APPEND;
      else if (r < 93) f = FN_INSERT;
      else f = FN_GROW;
    end
    send_word(f, idx, val, req);
    pause_random();
  endtask

  task automatic test_random_traffic();
    logic [6:0]  sizes [10];
    int unsigned phase;
    int unsigned k;
    sizes = '{7'd1, 7'd64, 7'd2, 7'd63, 7'd8, 7'd0, 7'd0, 7'd1, 7'd0, 7'd64};
    for (phase = 0; phase < 10; phase++) begin
      if (sizes[phase] == 0) sizes[phase] = 7'($urandom_range(1, 64));
      write_size(sizes[phase]);
      gaps_on = (phase % 4) != 3;
      for (k = 0; k < 150; k++) random_word(((k / 40) % 2) == 0);
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin : check_words
    table_word_t want;
    if (!rst && done === 1'b1) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: read_value %h error %0d size_now %0d count_now %0d",
                   read_value, error, size_now, count_now);
      end else begin
        want = pending_words.pop_front();
        if (read_value !== want.read_value || error !== want.error ||
            size_now !== want.size_now || count_now !== want.count_now) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"word mismatch: read_value exp %h got %h, error exp %0d got %0d, ",
                      "size_now exp %0d got %0d, count_now exp %0d got %0d"},
                     want.read_value, read_value, want.error, error,
                     want.size_now, size_now, want.count_now, count_now);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("shifting_array_table: mismatch");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    func       = '0;
    index      = '0;
    value      = '0;
    new_size   = '0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    gaps_on    = 1'b1;
    mismatches = 0;
    foreach (slot_mem[i]) slot_mem[i] = '0;
    cur_size  = clamp_size(INIT_SIZE_RESET);
    cur_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_directed();
    test_capacity_limit();
    test_random_traffic();
    drain_and_settle();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("shifting_array_table: match");
    end else begin
      $display("shifting_array_table: mismatch");
    end
    $finish;
  end

endmodule

// ----- shifting_array_table.f -----
hw/rtl/sat_pkg.sv
hw/rtl/sat_cell.sv
hw/rtl/shifting_array_table.sv
verif/shifting_array_table_test.sv
